[rtl/core/websocket_frame_unmasker_defines.svh]
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define WFU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wfu: assertion failed");

// next-cycle implication
`define WFU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wfu: assertion failed");

`endif

[rtl/core/wfu_pkg.sv]
package wfu_pkg;

	typedef enum logic [5:0] {
		PH_HDR0    = 6'b000001,
		PH_HDR1    = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_HALT    = 6'b100000
	} phase_t;

	// one decoded payload beat, key byte already selected
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
		logic       trunc;
	} beat_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [3:0] OPCODE_RESET = 4'h2;
	localparam logic [3:0] OPCODE_MASK  = 4'hF;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [3:0] EXT16_BYTES  = 4'd2;
	localparam logic [3:0] EXT64_BYTES  = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

endpackage

[rtl/core/wfu_queue.sv]
module wfu_queue import wfu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  beat_t push_beat,
	output logic  full,
	input  logic  pop,
	output beat_t pop_beat,
	output logic  not_empty
);

	beat_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_beat  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/wfu_front.sv]
module wfu_front import wfu_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       opcode_we,
	input  logic [3:0] opcode_wdata,
	input  logic       in_valid,
	input  logic [7:0] data_byte,
	input  logic       buffer_end,
	output logic       beat_valid,
	output beat_t      beat
);

	localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_BUFFER_BYTES - 1);

	logic [3:0]    opcode_q;
	phase_t        phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [3:0]    hdr_q, hdr_d;
	logic          masked_q, masked_d;
	logic [63:0]   len_q, len_d;
	logic [31:0]   key_q, key_d;
	logic [1:0]    kidx_q, kidx_d;

	logic        last;
	logic        len_done;
	logic [3:0]  hdr_dec;
	logic [63:0] len_dec;
	logic [7:0]  key_byte;

	assign last     = buffer_end || (pos_q == POS_LAST);
	assign hdr_dec  = hdr_q - 4'd1;
	assign len_dec  = len_q - 64'd1;
	// key byte 0 sits in the top byte
	assign key_byte = masked_q ? key_q[{~kidx_q, 3'b000} +: 8] : 8'h00;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		hdr_d      = hdr_q;
		masked_d   = masked_q;
		len_d      = len_q;
		key_d      = key_q;
		kidx_d     = kidx_q;
		len_done   = 1'b0;
		beat_valid = 1'b0;
		beat.data  = data_byte;
		beat.key   = key_byte;
		beat.last  = (len_dec == '0) || last;
		beat.trunc = (len_dec != '0) && last;

		if (in_valid) begin
			if (phase_q == PH_HALT) begin
				if (buffer_end) begin
					phase_d  = PH_HDR0;
					pos_d    = '0;
					hdr_d    = '0;
					masked_d = 1'b0;
					len_d    = '0;
					key_d    = '0;
					kidx_d   = '0;
				end
			end else begin
				pos_d = pos_q + 1'b1;
				unique case (phase_q)
					PH_HDR0: begin
						phase_d = ((data_byte[3:0] & OPCODE_MASK) == opcode_q) ? PH_HDR1
							: PH_HALT;
					end
					PH_HDR1: begin
						masked_d = data_byte[7];
						len_d    = '0;
						if (data_byte[6:0] == LEN_EXT16) begin
							hdr_d   = EXT16_BYTES;
							phase_d = PH_EXTLEN;
						end else if (data_byte[6:0] == LEN_EXT64) begin
							hdr_d   = EXT64_BYTES;
							phase_d = PH_EXTLEN;
						end else begin
							len_d    = 64'(data_byte[6:0]);
							len_done = 1'b1;
						end
					end
					PH_EXTLEN: begin
						len_d = {len_q[55:0], data_byte};
						hdr_d = hdr_dec;
						if (hdr_dec == '0) begin
							len_done = 1'b1;
						end
					end
					PH_KEY: begin
						key_d = {key_q[23:0], data_byte};
						hdr_d = hdr_dec;
						if (hdr_dec == '0) begin
							phase_d = (len_q == '0) ? PH_HDR0 : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						beat_valid = 1'b1;
						kidx_d     = kidx_q + 1'b1;
						len_d      = len_dec;
						if (len_dec == '0) begin
							phase_d = PH_HDR0;
						end
					end
					default: phase_d = PH_HALT;
				endcase

				if (len_done) begin
					kidx_d = '0;
					if (masked_d) begin
						hdr_d   = KEY_BYTES;
						key_d   = '0;
						phase_d = PH_KEY;
					end else begin
						phase_d = (len_d == '0) ? PH_HDR0 : PH_PAYLOAD;
					end
				end

				// end of buffer or cap: rearm, or ignore up to the real end
				if (last) begin
					if (buffer_end) begin
						phase_d  = PH_HDR0;
						pos_d    = '0;
						hdr_d    = '0;
						masked_d = 1'b0;
						len_d    = '0;
						key_d    = '0;
						kidx_d   = '0;
					end else begin
						phase_d = PH_HALT;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q <= OPCODE_RESET;
			phase_q  <= PH_HDR0;
			pos_q    <= '0;
			hdr_q    <= '0;
			masked_q <= 1'b0;
			len_q    <= '0;
			key_q    <= '0;
			kidx_q   <= '0;
		end else begin
			if (opcode_we) begin
				opcode_q <= opcode_wdata & OPCODE_MASK;
			end
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			hdr_q    <= hdr_d;
			masked_q <= masked_d;
			len_q    <= len_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
		end
	end

endmodule

[rtl/core/wfu_back.sv]
module wfu_back import wfu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  beat_t      q_beat,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] payload_byte,
	output logic       frame_last,
	output logic       truncated
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       trunc_q;

	logic pop_ok;

	assign pop_ok = pop && valid_q;
	assign q_pop  = q_valid && (!valid_q || pop_ok);

	assign empty        = !valid_q;
	assign payload_byte = byte_q;
	assign frame_last   = last_q;
	assign truncated    = trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop_ok) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q  <= q_beat.data ^ q_beat.key;
			last_q  <= q_beat.last;
			trunc_q <= q_beat.trunc;
		end
	end

endmodule

[rtl/core/websocket_frame_unmasker.sv]
// WebSocket frame deframer and unmasker. Takes one captured buffer a byte per
// beat (buffer_end on its last byte), parses back-to-back frame headers and
// returns each payload byte, XORed with the rotating masking key when the frame
// is masked. frame_last marks the last available payload byte of a frame;
// truncated also marks it when the buffer ends first. A frame whose opcode
// differs from accepted_opcode (reset 2) stops the buffer until buffer_end;
// bytes beyond MAX_BUFFER_BYTES are dropped. Header bytes give no result.
// Throughput is one byte per cycle while full is low: the header parser handles
// each byte as it is accepted, including the 64-bit length countdown. A payload
// byte is written into the queue when accepted and moves on to the result
// ports once the output register is free. full rises only when a four-beat
// queue and the output register hold results nobody has popped.
// Write accepted_opcode only while the block is idle.
module websocket_frame_unmasker import wfu_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accepted_opcode_we,
	input  logic [3:0] accepted_opcode,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       buffer_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] payload_byte,
	output logic       frame_last,
	output logic       truncated
);

	logic  in_valid;
	logic  beat_valid;
	beat_t beat;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;
	beat_t q_beat;

	assign full     = q_full;
	assign in_valid = push && !q_full;

	wfu_front #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode_we   (accepted_opcode_we),
		.opcode_wdata(accepted_opcode),
		.in_valid    (in_valid),
		.data_byte   (data_byte),
		.buffer_end  (buffer_end),
		.beat_valid  (beat_valid),
		.beat        (beat)
	);

	wfu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (beat_valid),
		.push_beat(beat),
		.full     (q_full),
		.pop      (q_pop),
		.pop_beat (q_beat),
		.not_empty(q_valid)
	);

	wfu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_beat      (q_beat),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.payload_byte(payload_byte),
		.frame_last  (frame_last),
		.truncated   (truncated)
	);

endmodule

[rtl/core/wfu_checker.sv]
`include "websocket_frame_unmasker_defines.svh"

module wfu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] payload_byte,
	input logic       frame_last,
	input logic       truncated
);

	// a waiting result holds until popped
	`WFU_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(payload_byte) && $stable(frame_last) && $stable(truncated))

	// a truncated beat always closes its frame
	`WFU_ASSERT_IMP(a_trunc_last, !empty && truncated, frame_last)

	// the queue fills only behind a loaded output register
	`WFU_ASSERT_IMP(a_full_has_out, full, !empty)

endmodule

bind websocket_frame_unmasker wfu_checker u_wfu_checker (.*);

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wfu_pkg::*;

	localparam int BUF_CAP      = 512;
	localparam int SETTLE       = 8;
	localparam int STALL_LIMIT  = 1000;
	localparam int HALF_PHASE   = 85;

	typedef struct {
		logic [7:0] data;
		logic       last_of_buffer;
	} raw_byte_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} payload_beat_t;

	logic       clk                = 1'b0;
	logic       arst_n             = 1'b0;
	logic       accepted_opcode_we = 1'b0;
	logic [3:0] accepted_opcode    = OPCODE_RESET;
	logic       push               = 1'b0;
	logic       full;
	logic [7:0] data_byte          = 8'h00;
	logic       buffer_end         = 1'b0;
	logic       empty;
	logic       pop                = 1'b0;
	logic [7:0] payload_byte;
	logic       frame_last;
	logic       truncated;

	websocket_frame_unmasker #(
		.MAX_BUFFER_BYTES(BUF_CAP)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.accepted_opcode_we(accepted_opcode_we),
		.accepted_opcode   (accepted_opcode),
		.push              (push),
		.full              (full),
		.data_byte         (data_byte),
		.buffer_end        (buffer_end),
		.empty             (empty),
		.pop               (pop),
		.payload_byte      (payload_byte),
		.frame_last        (frame_last),
		.truncated         (truncated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// deframer state mirrored by the testbench model
	phase_t      dec_phase;
	int          buf_pos;
	logic [3:0]  hdr_left;
	logic        dec_masked;
	logic [63:0] len_left;
	logic [31:0] mask_key;
	logic [1:0]  key_idx;
	logic [3:0]  opc_model;

	raw_byte_t     pending_bytes[$];
	payload_beat_t payload_expected[$];

	logic [3:0] stim_opcode;
	logic [3:0] mid_opcode;
	int  bytes_queued;
	int  beats_in;
	int  beats_out;
	int  buffers_done;
	int  capped_buffers;
	int  truncated_ends;
	int  errors;
	int  idle_cycles;
	logic in_fire = 1'b0;

	// sender burst state and receiver stall pattern
	int        burst_left = 0;
	int        gap_left   = 0;
	raw_byte_t next_byte;
	logic [15:0] rx_pattern = 16'hFFFF;
	int        pat_left   = 0;

	task automatic clear_parser();
		dec_phase  = PH_HDR0;
		buf_pos    = 0;
		hdr_left   = '0;
		dec_masked = 1'b0;
		len_left   = '0;
		mask_key   = '0;
		key_idx    = '0;
	endtask

	task automatic after_length();
		key_idx = '0;
		if (dec_masked) begin
			hdr_left  = KEY_BYTES;
			mask_key  = '0;
			dec_phase = PH_KEY;
		end else begin
			dec_phase = (len_left == 0) ? PH_HDR0 : PH_PAYLOAD;
		end
	endtask

	task automatic unmask_byte(input logic [7:0] b, input logic endf);
		logic          at_last;
		logic          done;
		logic [7:0]    k;
		payload_beat_t r;
		if (dec_phase == PH_HALT || buf_pos >= BUF_CAP) begin
			if (endf)
				clear_parser();
		end else begin
			at_last = endf || (buf_pos == BUF_CAP - 1);
			if (buf_pos == BUF_CAP - 1)
				capped_buffers++;
			buf_pos++;
			case (dec_phase)
				PH_HDR0: begin
					dec_phase = (b[3:0] == opc_model) ? PH_HDR1 : PH_HALT;
				end
				PH_HDR1: begin
					dec_masked = b[7];
					len_left   = '0;
					if (b[6:0] == LEN_EXT16) begin
						hdr_left  = EXT16_BYTES;
						dec_phase = PH_EXTLEN;
					end else if (b[6:0] == LEN_EXT64) begin
						hdr_left  = EXT64_BYTES;
						dec_phase = PH_EXTLEN;
					end else begin
						len_left = {57'd0, b[6:0]};
						after_length();
					end
				end
				PH_EXTLEN: begin
					len_left = {len_left[55:0], b};
					hdr_left = hdr_left - 1'b1;
					if (hdr_left == 0)
						after_length();
				end
				PH_KEY: begin
					mask_key = {mask_key[23:0], b};
					hdr_left = hdr_left - 1'b1;
					if (hdr_left == 0)
						dec_phase = (len_left == 0) ? PH_HDR0 : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					k        = dec_masked ? mask_key[31 - 8 * int'(key_idx) -: 8] : 8'h00;
					key_idx  = key_idx + 1'b1;
					len_left = len_left - 1'b1;
					done     = (len_left == 0);
					r.data   = b ^ k;
					r.last   = done || at_last;
					r.trunc  = !done && at_last;
					payload_expected.insert(payload_expected.size(), r);
					if (done)
						dec_phase = PH_HDR0;
				end
				default: begin
					dec_phase = PH_HALT;
				end
			endcase
			if (at_last) begin
				if (endf)
					clear_parser();
				else
					dec_phase = PH_HALT;
			end
		end
	endtask

	// accept tracking, result checking and prediction, all on the rising edge
	always @(posedge clk) begin
		payload_beat_t exp_beat;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			if (pop && !empty) begin
				beats_out++;
				if (payload_expected.size() == 0) begin
					$error("payload beat %02h with nothing expected", payload_byte);
					errors++;
				end else begin
					exp_beat = payload_expected.pop_front();
					if (exp_beat.trunc)
						truncated_ends++;
					if (payload_byte !== exp_beat.data) begin
						$error("payload_byte: expected %02h, got %02h",
							exp_beat.data, payload_byte);
						errors++;
					end
					if (frame_last !== exp_beat.last) begin
						$error("frame_last: expected %0b, got %0b", exp_beat.last, frame_last);
						errors++;
					end
					if (truncated !== exp_beat.trunc) begin
						$error("truncated: expected %0b, got %0b", exp_beat.trunc, truncated);
						errors++;
					end
				end
			end
			in_fire <= push && !full;
			if (push && !full) begin
				beats_in++;
				if (buffer_end)
					buffers_done++;
				unmask_byte(data_byte, buffer_end);
			end
			if (accepted_opcode_we)
				opc_model = accepted_opcode;
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// sender: bursts of random length, random gaps in between
	always @(negedge clk) begin
		if (arst_n && !(push && !in_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				next_byte = pending_bytes.pop_front();
				push       <= 1'b1;
				data_byte  <= next_byte.data;
				buffer_end <= next_byte.last_of_buffer;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: rotating pop pattern, swapped every so often
	always @(negedge clk) begin
		if (pat_left == 0) begin
			case ($urandom_range(0, 3))
				0: rx_pattern = 16'hFFFF;
				1: rx_pattern = 16'h8001;
				2: rx_pattern = 16'hF0F0;
				default: rx_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
			endcase
			pat_left = $urandom_range(16, 96);
		end else begin
			pat_left--;
		end
		pop <= rx_pattern[0];
		rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic endf);
		raw_byte_t item;
		item.data           = b;
		item.last_of_buffer = endf;
		pending_bytes.insert(pending_bytes.size(), item);
		bytes_queued++;
	endtask

	// bytes packed most significant first, n of them, end flag on the last
	task automatic queue_directed(input logic [255:0] v, input int n);
		for (int i = 0; i < n; i++)
			queue_byte(v[8 * (n - 1 - i) +: 8], i == n - 1);
	endtask

	task automatic queue_random_buffer(input logic [3:0] opcode, input bit long_one);
		logic [7:0]  bytes[$];
		logic [63:0] len;
		logic [3:0]  op;
		logic [3:0]  nib;
		int          nframes;
		int          kind;
		int          nbytes;
		int          cut;
		bit          masked;
		bit          open_ended;
		if (!long_one && $urandom_range(0, 9) == 0) begin
			// noise
			nbytes = $urandom_range(1, 12);
			repeat (nbytes) bytes.insert(bytes.size(), rand_byte());
		end else begin
			nframes    = long_one ? 1 : $urandom_range(1, 4);
			open_ended = 1'b0;
			for (int f = 0; f < nframes && !open_ended; f++) begin
				op  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : opcode;
				nib = 4'($urandom_range(0, 15));
				bytes.insert(bytes.size(), {nib, op});
				masked = 1'($urandom_range(0, 1));
				kind   = long_one ? 6 : $urandom_range(0, 9);
				if (kind <= 5) begin
					len = 64'((kind == 5) ? $urandom_range(0, 125) : $urandom_range(0, 12));
					bytes.insert(bytes.size(), {masked, len[6:0]});
				end else if (kind <= 7) begin
					len = 64'(long_one ? $urandom_range(520, 540) : $urandom_range(0, 40));
					bytes.insert(bytes.size(), {masked, LEN_EXT16});
					bytes.insert(bytes.size(), len[15:8]);
					bytes.insert(bytes.size(), len[7:0]);
				end else begin
					if (kind == 8) begin
						len = 64'($urandom_range(0, 30));
					end else begin
						// runs past any buffer
						len = {32'($urandom_range(0, 32'hFFFF_FFFF)),
							32'($urandom_range(0, 32'hFFFF_FFFF))};
						if (len[63:16] == 0)
							len[40] = 1'b1;
					end
					bytes.insert(bytes.size(), {masked, LEN_EXT64});
					for (int i = 7; i >= 0; i--)
						bytes.insert(bytes.size(), len[8 * i +: 8]);
				end
				if (masked)
					repeat (4) bytes.insert(bytes.size(), rand_byte());
				open_ended = (kind == 9) || (op != opcode);
				nbytes     = (kind == 9) ? $urandom_range(0, 12) : int'(len);
				repeat (nbytes) bytes.insert(bytes.size(), rand_byte());
			end
			if (!long_one && $urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, bytes.size());
				while (bytes.size() > cut)
					void'(bytes.pop_back());
			end
		end
		foreach (bytes[i])
			queue_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// every queued byte accepted and every predicted beat popped
	task automatic wait_until_drained();
		while (pending_bytes.size() != 0 || push || beats_in != bytes_queued
			|| payload_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_opcode(input logic [3:0] v);
		accepted_opcode    <= v;
		accepted_opcode_we <= 1'b1;
		@(negedge clk);
		accepted_opcode_we <= 1'b0;
		stim_opcode = v;
	endtask

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$error("no beat accepted for %0d cycles", STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [3:0] phase_opcodes[4];
		int         target;
		errors         = 0;
		idle_cycles    = 0;
		bytes_queued   = 0;
		beats_in       = 0;
		beats_out      = 0;
		buffers_done   = 0;
		capped_buffers = 0;
		truncated_ends = 0;
		opc_model      = OPCODE_RESET;
		stim_opcode    = OPCODE_RESET;
		clear_parser();
		mid_opcode       = 4'($urandom_range(1, 14));
		phase_opcodes[0] = 4'h0;
		phase_opcodes[1] = OPCODE_MASK;
		phase_opcodes[2] = mid_opcode;
		phase_opcodes[3] = OPCODE_RESET;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero-length frame, then masked frame whose key wraps around
		queue_directed(256'({8'h82, 8'h00, 8'h82, 8'h85, 8'h12, 8'h34, 8'h56, 8'h78,
			8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01}), 13);
		// 64-bit all-ones length, cut short by buffer end
		queue_directed(256'({8'hF2, 8'h7F, {8{8'hFF}}, 8'h00, 8'hFF}), 12);
		// wrong opcode, rest ignored
		queue_directed(256'({8'h8F, 8'h01, 8'h33}), 3);
		// buffer ends inside the 16-bit length
		queue_directed(256'({8'h82, 8'hFE, 8'h00}), 3);
		wait_until_drained();

		for (int p = 0; p < 4; p++) begin
			write_opcode(phase_opcodes[p]);
			if (p == 2)
				queue_random_buffer(stim_opcode, 1'b1);
			for (int h = 0; h < 2; h++) begin
				target = bytes_queued + HALF_PHASE;
				while (bytes_queued < target)
					queue_random_buffer(stim_opcode, 1'b0);
				wait_until_drained();
			end
		end

		$display("Ran %0d byte beats over %0d buffers (%0d hit the size cap),",
			beats_in, buffers_done, capped_buffers);
		$display("opcodes 0, 15, %0d, 2; checked %0d payload beats, %0d truncated frame ends.",
			mid_opcode, beats_out, truncated_ends);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
